FILE: design/dttc_pkg.sv
// Package for the disc time-to-collision block: payload types, outcome codes, stage records.
package dttc_pkg;

  localparam logic [1:0] OUT_OVERLAP = 2'd0;
  localparam logic [1:0] OUT_COLLIDE = 2'd1;
  localparam logic [1:0] OUT_NEVER   = 2'd2;

  // digits of the square root and quotient bits of the divider
  localparam int SqrtSteps = 57;
  localparam int DivSteps  = 32;

  typedef struct packed {
    logic [31:0] self_x;
    logic [31:0] self_y;
    logic [23:0] self_vx;
    logic [23:0] self_vy;
    logic [22:0] self_radius;
    logic [31:0] other_x;
    logic [31:0] other_y;
    logic [23:0] other_vx;
    logic [23:0] other_vy;
    logic [22:0] other_radius;
  } pair_t;

  typedef struct packed {
    logic [1:0]  outcome;
    logic [31:0] time_left;
  } result_t;

  // square root stage record
  typedef struct packed {
    logic [1:0]   outc;
    logic [113:0] d;
    logic [57:0]  rem;
    logic [56:0]  root;
    logic [56:0]  ub;
    logic [48:0]  a;
  } sq_t;

  // divider stage record
  typedef struct packed {
    logic [1:0]  outc;
    logic        sat;
    logic [48:0] r;
    logic [48:0] a;
    logic [15:0] nlo;
    logic [31:0] q;
  } dv_t;

endpackage

FILE: design/dttc_stream_if.sv
// Valid/ready stream interface carrying one payload per transaction.
interface dttc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: design/disc_time_to_collision.sv
// Disc time-to-collision: one pair of moving discs in, one outcome and touch time out,
// fully pipelined; a transaction is taken every cycle unless the pipe is full and stalled.
// Front stages of products, sums and split wide multiplies lead to 57 square-root digit
// stages, one numerator stage, 32 restoring-division stages and the output register. Each
// stage holds its data while the stage after it is full and stalled, so bubbles are
// squeezed out and input is taken while a finished result waits. Outcome 0: overlapping,
// 1: will touch (time_left in Q16.16 seconds, saturating at all ones), 2: never touches.
module disc_time_to_collision (
  input  logic          clk,
  input  logic          rst,
  dttc_stream_if.sink   pair,
  dttc_stream_if.source result
);

  localparam int NumFront = 8;
  localparam int SqBase   = NumFront;
  localparam int NumIdx   = SqBase + dttc_pkg::SqrtSteps;
  localparam int DvBase   = NumIdx + 1;
  localparam int OutIdx   = DvBase + dttc_pkg::DivSteps;
  localparam int NumStg   = OutIdx + 1;

  logic [NumStg-1:0] vld;
  logic [NumStg:0]   adv;

  assign adv[NumStg] = result.ready;
  assign pair.ready  = adv[0];
  assign result.valid = vld[OutIdx];

  for (genvar i = 0; i < NumStg; i++) begin : g_adv
    assign adv[i] = ~vld[i] | adv[i+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= pair.valid;
      for (int i = 1; i < NumStg; i++) begin
        if (adv[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // stage 0: offsets and relative velocity
  logic signed [32:0] wx, wy;
  logic signed [24:0] vx, vy;
  logic [23:0]        rad;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      wx  <= $signed({pair.data.other_x[31], pair.data.other_x})
           - $signed({pair.data.self_x[31], pair.data.self_x});
      wy  <= $signed({pair.data.other_y[31], pair.data.other_y})
           - $signed({pair.data.self_y[31], pair.data.self_y});
      vx  <= $signed({pair.data.self_vx[23], pair.data.self_vx})
           - $signed({pair.data.other_vx[23], pair.data.other_vx});
      vy  <= $signed({pair.data.self_vy[23], pair.data.self_vy})
           - $signed({pair.data.other_vy[23], pair.data.other_vy});
      rad <= {1'b0, pair.data.self_radius} + {1'b0, pair.data.other_radius};
    end
  end

  // stage 1: products
  logic signed [65:0] pwx, pwy;
  logic signed [49:0] pvx, pvy;
  logic signed [57:0] pbx, pby;
  logic [47:0]        rr1;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      pwx <= wx * wx;
      pwy <= wy * wy;
      pvx <= vx * vx;
      pvy <= vy * vy;
      pbx <= wx * vx;
      pby <= wy * vy;
      rr1 <= rad * rad;
    end
  end

  // stage 2: dot products
  logic [65:0]        ww;
  logic [48:0]        a2;
  logic signed [57:0] b2;
  logic [47:0]        rr2;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      ww  <= {1'b0, pwx[64:0]} + {1'b0, pwy[64:0]};
      a2  <= pvx[48:0] + pvy[48:0];
      b2  <= pbx + pby;
      rr2 <= rr1;
    end
  end

  // stage 3: overlap and early-out decisions
  logic [1:0]  outc3;
  logic [65:0] c3;
  logic [48:0] a3;
  logic [56:0] ub3;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      if (ww < 66'(rr2)) outc3 <= dttc_pkg::OUT_OVERLAP;
      else if (a2 == '0 || b2[57] || b2 == '0) outc3 <= dttc_pkg::OUT_NEVER;
      else outc3 <= dttc_pkg::OUT_COLLIDE;
      c3  <= ww - 66'(rr2);
      a3  <= a2;
      ub3 <= b2[56:0];
    end
  end

  // stage 4: partial products of B*B and A*C
  logic [55:0] bhh;
  logic [56:0] blh;
  logic [57:0] bll;
  logic [56:0] ahh, ahl;
  logic [57:0] alh, all4;
  logic [1:0]  outc4;
  logic [48:0] a4;
  logic [56:0] ub4;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      bhh   <= ub3[56:29] * ub3[56:29];
      blh   <= ub3[28:0] * ub3[56:29];
      bll   <= ub3[28:0] * ub3[28:0];
      ahh   <= a3[48:25] * c3[65:33];
      ahl   <= a3[48:25] * c3[32:0];
      alh   <= a3[24:0] * c3[65:33];
      all4  <= a3[24:0] * c3[32:0];
      outc4 <= outc3;
      a4    <= a3;
      ub4   <= ub3;
    end
  end

  // stage 5: B*B complete, A*C middle terms (weights 2^25 and 2^33)
  logic [113:0] bb5;
  logic [66:0]  acm;
  logic [56:0]  ahh5;
  logic [57:0]  all5;
  logic [1:0]   outc5;
  logic [48:0]  a5;
  logic [56:0]  ub5;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      bb5   <= (114'(bhh) << 58) + (114'(blh) << 30) + 114'(bll);
      acm   <= 67'(ahl) + (67'(alh) << 8);
      ahh5  <= ahh;
      all5  <= all4;
      outc5 <= outc4;
      a5    <= a4;
      ub5   <= ub4;
    end
  end

  // stage 6: A*C complete
  logic [113:0] bb6, ac6;
  logic [1:0]   outc6;
  logic [48:0]  a6;
  logic [56:0]  ub6;

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      bb6   <= bb5;
      ac6   <= (114'(ahh5) << 58) + (114'(acm) << 25) + 114'(all5);
      outc6 <= outc5;
      a6    <= a5;
      ub6   <= ub5;
    end
  end

  // stage 7: discriminant
  dttc_pkg::sq_t sq [0:dttc_pkg::SqrtSteps];

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      if (outc6 == dttc_pkg::OUT_COLLIDE && bb6 <= ac6) sq[0].outc <= dttc_pkg::OUT_NEVER;
      else sq[0].outc <= outc6;
      sq[0].d    <= bb6 - ac6;
      sq[0].rem  <= '0;
      sq[0].root <= '0;
      sq[0].ub   <= ub6;
      sq[0].a    <= a6;
    end
  end

  // square root, one digit per stage, most significant pair first
  for (genvar k = 0; k < dttc_pkg::SqrtSteps; k++) begin : g_sq
    localparam int P = dttc_pkg::SqrtSteps - 1 - k;
    logic [59:0] r2, t2;
    assign r2 = {sq[k].rem, sq[k].d[2*P+1:2*P]};
    assign t2 = {1'b0, sq[k].root, 2'b01};

    always_ff @(posedge clk) begin
      if (adv[SqBase+k]) begin
        sq[k+1].outc <= sq[k].outc;
        sq[k+1].d    <= sq[k].d;
        sq[k+1].ub   <= sq[k].ub;
        sq[k+1].a    <= sq[k].a;
        if (r2 >= t2) begin
          sq[k+1].rem  <= 58'(r2 - t2);
          sq[k+1].root <= {sq[k].root[55:0], 1'b1};
        end else begin
          sq[k+1].rem  <= r2[57:0];
          sq[k+1].root <= {sq[k].root[55:0], 1'b0};
        end
      end
    end
  end

  // numerator B - floor(sqrt(D)) and saturation check
  dttc_pkg::dv_t dv [0:dttc_pkg::DivSteps];
  logic [56:0]   num;

  assign num = sq[dttc_pkg::SqrtSteps].ub - sq[dttc_pkg::SqrtSteps].root;

  always_ff @(posedge clk) begin
    if (adv[NumIdx]) begin
      dv[0].outc <= sq[dttc_pkg::SqrtSteps].outc;
      dv[0].sat  <= 49'(num[56:16]) >= sq[dttc_pkg::SqrtSteps].a;
      dv[0].r    <= 49'(num[56:16]);
      dv[0].a    <= sq[dttc_pkg::SqrtSteps].a;
      dv[0].nlo  <= num[15:0];
      dv[0].q    <= '0;
    end
  end

  // restoring division of num * 2^16 by A, one quotient bit per stage
  for (genvar k = 0; k < dttc_pkg::DivSteps; k++) begin : g_dv
    localparam int J = dttc_pkg::DivSteps - 1 - k;
    logic        nb;
    logic [49:0] r2;
    if (J >= 16) begin : g_num
      assign nb = dv[k].nlo[J-16];
    end else begin : g_zero
      assign nb = 1'b0;
    end
    assign r2 = {dv[k].r, nb};

    always_ff @(posedge clk) begin
      if (adv[DvBase+k]) begin
        dv[k+1].outc <= dv[k].outc;
        dv[k+1].sat  <= dv[k].sat;
        dv[k+1].a    <= dv[k].a;
        dv[k+1].nlo  <= dv[k].nlo;
        if (r2 >= {1'b0, dv[k].a}) begin
          dv[k+1].r <= 49'(r2 - {1'b0, dv[k].a});
          dv[k+1].q <= dv[k].q | (32'd1 << J);
        end else begin
          dv[k+1].r <= r2[48:0];
          dv[k+1].q <= dv[k].q;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (adv[OutIdx]) begin
      result.data.outcome <= dv[dttc_pkg::DivSteps].outc;
      if (dv[dttc_pkg::DivSteps].outc != dttc_pkg::OUT_COLLIDE) result.data.time_left <= '0;
      else if (dv[dttc_pkg::DivSteps].sat) result.data.time_left <= '1;
      else result.data.time_left <= dv[dttc_pkg::DivSteps].q;
    end
  end

endmodule

FILE: design/dttc_checker.sv
// Port-level checks for the disc time-to-collision block, with the bind to the top level.
module dttc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  outcome,
  input logic [31:0] time_left
);

  // a time is only given for a coming collision
  a_time_only_collide: assert property (@(posedge clk) disable iff (rst)
    out_valid && outcome != dttc_pkg::OUT_COLLIDE |-> time_left == '0)
    else $error("time_left nonzero without a collision outcome");

  // an open output never stalls the input side
  a_ready_flows: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output is ready");

  // nothing comes out right after reset
  a_empty_after_rst: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(outcome) && $stable(time_left))
    else $error("stalled result changed");

  // handshake lines are always known out of reset
  a_known: assert property (@(posedge clk) disable iff (rst)
    !$isunknown({in_valid, in_ready, out_valid, out_ready}))
    else $error("unknown value on a handshake line");

endmodule

bind disc_time_to_collision dttc_checker u_dttc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pair.valid),
  .in_ready  (pair.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .outcome   (result.data.outcome),
  .time_left (result.data.time_left)
);
